// ----- design/egc_pkg.sv -----
// ----------------------------------------------------------------------------
// egc_pkg: shared types and constants of the EGA graphics controller
// Register indexes, mode codes and the configuration bundle.
// ----------------------------------------------------------------------------
package egc_pkg;

	localparam int ADDR_IN_W = 14;   // width of the CPU address field
	localparam int DATA_W    = 8;    // one plane byte
	localparam int PLANES    = 4;
	localparam int WORD_W    = DATA_W * PLANES;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;
	// Smallest plane depth is 1024, so a 14-bit address wraps at most 15 times.
	localparam int QUOT_W    = 4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam int GM_READ_MODE_BIT = 3;
	localparam logic [DATA_W-1:0] READ_MODE1_DATA = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_MASK         = 3'd0,
		REG_SET_RESET        = 3'd1,
		REG_ENABLE_SET_RESET = 3'd2,
		REG_DATA_ROTATE      = 3'd3,
		REG_READ_MAP_SELECT  = 3'd4,
		REG_GRAPHICS_MODE    = 3'd5,
		REG_BIT_MASK         = 3'd6
	} egc_reg_t;

	typedef enum logic [1:0] {
		WM_ROTATE = 2'd0,
		WM_LATCH  = 2'd1,
		WM_EXPAND = 2'd2,
		WM_NONE   = 2'd3
	} wmode_t;

	typedef enum logic [1:0] {
		ALU_COPY = 2'd0,
		ALU_AND  = 2'd1,
		ALU_OR   = 2'd2,
		ALU_XOR  = 2'd3
	} alu_t;

	typedef struct packed {
		logic [PLANES-1:0] map_mask;
		logic [PLANES-1:0] set_reset;
		logic [PLANES-1:0] enable_set_reset;
		logic [4:0]        data_rotate;
		logic [1:0]        read_map_select;
		logic [7:0]        graphics_mode;
		logic [DATA_W-1:0] bit_mask;
	} egc_cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] wdata;
		logic [PLANES-1:0] byte_en;
	} egc_wr_t;

endpackage

// ----- design/ega_graphics_controller.sv -----
// ----------------------------------------------------------------------------
// ega_graphics_controller: EGA graphics controller with planar video memory
// CPU read/write accesses through the latches, write modes and bit mask.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: start with operation, address and write_data issues one
//   access; it is taken at a clock edge where start is high and busy is low.
//   busy stays low, so one access can be issued every cycle.
//   Result channel: each read returns one byte on read_data, marked by done
//   for exactly one cycle, once the access has passed stage 1 and stage 2. Writes
//   return nothing. The receiver cannot stall; results are never held.
//   Configuration: cfg_we/cfg_index/cfg_wdata write one register per edge;
//   indexes past the bit mask register are dropped. Write only while idle.
// Timing:
//   Stage 1 registers the access and the coarse address wrap quotient; the
//   final address, the write data path and the memory access happen there.
//   Stage 2 holds the registered memory read word, which feeds read_data
//   and the latches. Throughput is one access per cycle, set by the single
//   memory port, which serves one read or one write per cycle.
// Reset:
//   arst_n clears the pipeline, the latches and the registers (map mask all
//   planes on). Video memory is not cleared; read only what was written.
// ----------------------------------------------------------------------------
module ega_graphics_controller
	import egc_pkg::*;
#(
	parameter int PLANE_BYTES = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  logic [ADDR_IN_W-1:0] address,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 done,
	output logic [DATA_W-1:0]    read_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int ADDR_W = $clog2(PLANE_BYTES);
	// Reciprocal of the depth in 32-bit fixed point, rounded up; exact for
	// 14-bit addresses since the rounding error stays below 2**-18.
	localparam longint unsigned RECIP = ((64'd1 << 32) + PLANE_BYTES - 1) / PLANE_BYTES;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = 32 + QUOT_W + 1;
	localparam int REM_W   = ADDR_IN_W + QUOT_W + 3;

	egc_cfg_t cfg;
	egc_wr_t  wr;
	egc_wr_t  wr_gated;

	logic                 accept;
	logic [PROD_W-1:0]    prod;
	logic [QUOT_W-1:0]    quot;

	// stage 1: registered access
	logic                 valid_s1;
	logic                 op_s1;
	logic [ADDR_IN_W-1:0] addr_s1;
	logic [DATA_W-1:0]    data_s1;
	logic [QUOT_W-1:0]    quot_s1;

	// stage 2: read result
	logic                 rd_valid_s2;
	logic [WORD_W-1:0]    rd_word;

	logic [WORD_W-1:0]    latch_q;
	logic [WORD_W-1:0]    latch_eff;
	logic [REM_W-1:0]     rem;
	logic [ADDR_W-1:0]    mem_addr;
	logic                 mem_re;
	logic                 wr_en;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Coarse quotient of the address by the plane depth.
	assign prod = PROD_W'(address) * PROD_W'(RECIP[RECIP_W-1:0]);
	assign quot = prod[32 +: QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rd_valid_s2 <= 1'b0;
		end else begin
			valid_s1    <= accept;
			rd_valid_s2 <= valid_s1 && (op_s1 == OP_READ);
		end
	end

	// Payload of stage 1; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			addr_s1 <= address;
			data_s1 <= write_data;
			quot_s1 <= quot;
		end
	end

	// Wrap the address into the plane: subtract quotient times depth.
	assign rem      = REM_W'(addr_s1) - REM_W'(quot_s1) * REM_W'(PLANE_BYTES);
	assign mem_addr = rem[ADDR_W-1:0];

	// Latches: a read in stage 2 loads them; forward it to a write behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
		end else if (rd_valid_s2) begin
			latch_q <= rd_word;
		end
	end

	assign latch_eff = rd_valid_s2 ? rd_word : latch_q;

	egc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	egc_write_unit u_wr (
		.cfg   (cfg),
		.data  (data_s1),
		.latch (latch_eff),
		.wr    (wr)
	);

	// Write only for a valid write access in stage 1.
	assign wr_en            = valid_s1 && (op_s1 == OP_WRITE);
	assign mem_re           = valid_s1 && (op_s1 == OP_READ);
	assign wr_gated.wdata   = wr.wdata;
	assign wr_gated.byte_en = wr_en ? wr.byte_en : '0;

	egc_plane_mem #(
		.DEPTH  (PLANE_BYTES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.addr  (mem_addr),
		.re    (mem_re),
		.wr    (wr_gated),
		.rdata (rd_word)
	);

	// Read mode 0 selects one plane byte; read mode 1 returns all ones.
	assign done      = rd_valid_s2;
	assign read_data = cfg.graphics_mode[GM_READ_MODE_BIT] ? READ_MODE1_DATA :
		rd_word[cfg.read_map_select*DATA_W +: DATA_W];

endmodule

// ----- design/egc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// egc_cfg_regs: graphics controller register file
// Write-only registers loaded from the plain configuration port.
// ----------------------------------------------------------------------------
module egc_cfg_regs
	import egc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	output egc_cfg_t             cfg
);

	egc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_mask         <= '1;
			cfg_q.set_reset        <= '0;
			cfg_q.enable_set_reset <= '0;
			cfg_q.data_rotate      <= '0;
			cfg_q.read_map_select  <= '0;
			cfg_q.graphics_mode    <= '0;
			cfg_q.bit_mask         <= '0;
		end else if (cfg_we) begin
			unique case (egc_reg_t'(cfg_index))
				REG_MAP_MASK:         cfg_q.map_mask         <= cfg_wdata[PLANES-1:0];
				REG_SET_RESET:        cfg_q.set_reset        <= cfg_wdata[PLANES-1:0];
				REG_ENABLE_SET_RESET: cfg_q.enable_set_reset <= cfg_wdata[PLANES-1:0];
				REG_DATA_ROTATE:      cfg_q.data_rotate      <= cfg_wdata[4:0];
				REG_READ_MAP_SELECT:  cfg_q.read_map_select  <= cfg_wdata[1:0];
				REG_GRAPHICS_MODE:    cfg_q.graphics_mode    <= cfg_wdata;
				REG_BIT_MASK:         cfg_q.bit_mask         <= cfg_wdata;
				default: ;  // drop writes past the last register
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/egc_write_unit.sv -----
// ----------------------------------------------------------------------------
// egc_write_unit: per-plane write data path
// Rotate, set/reset, expand, ALU against the latch and bit-mask merge.
// ----------------------------------------------------------------------------
module egc_write_unit
	import egc_pkg::*;
(
	input  egc_cfg_t          cfg,
	input  logic [DATA_W-1:0] data,
	input  logic [WORD_W-1:0] latch,
	output egc_wr_t           wr
);

	wmode_t              wmode;
	alu_t                alu_fn;
	logic [2*DATA_W-1:0] doubled;
	logic [DATA_W-1:0]   rot;
	logic [DATA_W-1:0]   lat   [PLANES];
	logic [DATA_W-1:0]   src   [PLANES];
	logic [DATA_W-1:0]   alu_r [PLANES];
	logic [DATA_W-1:0]   nb    [PLANES];

	always_comb begin
		wmode   = wmode_t'(cfg.graphics_mode[1:0]);
		alu_fn  = alu_t'(cfg.data_rotate[4:3]);
		doubled = {data, data};
		rot     = DATA_W'(doubled >> cfg.data_rotate[2:0]);
		for (int p = 0; p < PLANES; p++) begin
			lat[p] = latch[p*DATA_W +: DATA_W];
			unique case (wmode)
				WM_ROTATE: src[p] = cfg.enable_set_reset[p] ?
					{DATA_W{cfg.set_reset[p]}} : rot;
				WM_EXPAND: src[p] = {DATA_W{data[p]}};
				default:   src[p] = rot;
			endcase
			unique case (alu_fn)
				ALU_COPY: alu_r[p] = src[p];
				ALU_AND:  alu_r[p] = src[p] & lat[p];
				ALU_OR:   alu_r[p] = src[p] | lat[p];
				ALU_XOR:  alu_r[p] = src[p] ^ lat[p];
				default:  alu_r[p] = src[p];
			endcase
			if (wmode == WM_LATCH) begin
				nb[p] = lat[p];
			end else begin
				nb[p] = (alu_r[p] & cfg.bit_mask) | (lat[p] & ~cfg.bit_mask);
			end
			wr.wdata[p*DATA_W +: DATA_W] = nb[p];
			wr.byte_en[p] = cfg.map_mask[p] && (wmode != WM_NONE);
		end
	end

endmodule

// ----- design/egc_plane_mem.sv -----
// ----------------------------------------------------------------------------
// egc_plane_mem: four-plane video memory
// One word per address, byte write enable per plane, registered read.
// ----------------------------------------------------------------------------
module egc_plane_mem
	import egc_pkg::*;
#(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	input  logic              re,
	input  egc_wr_t           wr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		for (int p = 0; p < PLANES; p++) begin
			if (wr.byte_en[p]) begin
				mem[addr][p*DATA_W +: DATA_W] <= wr.wdata[p*DATA_W +: DATA_W];
			end
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/egc_checker.sv -----
// ----------------------------------------------------------------------------
// egc_checker: port-level checks of the EGA graphics controller
// Command/result timing as seen on the top-level ports.
// ----------------------------------------------------------------------------
module egc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done
);

	// Accept every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// A result only follows a read taken ahead of it through stage 1 and stage 2.
	a_done_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && !operation, 2))
		else $error("result without a read");

	// Every read taken gives its result once it has passed stage 1 and stage 2.
	a_read_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(start && !busy && !operation, 2) && $past(arst_n, 1)
			&& $past(arst_n, 2)) |-> done)
		else $error("read result missing");

	// A write gives no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && operation, 2) |-> !done)
		else $error("result for a write");

endmodule

bind ega_graphics_controller egc_checker u_egc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.done      (done)
);

// ----- dv/ega_graphics_controller_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ega_graphics_controller_test: self-checking bench of the EGA graphics controller
// Issues CPU reads and writes to planar video memory under changing register
// settings and checks every returned read byte against a shadow copy of the
// planes, latches and registers kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module ega_graphics_controller_test;
	import egc_pkg::*;

	localparam int PLANE_DEPTH  = 16384;
	localparam int ACCESS_GOAL  = 2000;
	localparam int PHASE_LEN    = 100;
	// Reads return through stage 1 and stage 2; writes land in memory from stage 1.
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 2000;
	// Index past the bit mask register; the block must drop it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Shadow of the video planes, latches and registers. Predicts the byte
	// of every read and checks returned words in order.
	class vram_mirror;
		bit [WORD_W-1:0]   plane_words[int];
		bit [PLANES-1:0]   planes_written[int];
		int                readable_addrs[$];
		logic [DATA_W-1:0] read_bytes_due[$];
		logic [WORD_W-1:0] latches;
		logic [3:0]        map_mask;
		logic [3:0]        set_reset;
		logic [3:0]        enable_set_reset;
		logic [4:0]        data_rotate;
		logic [1:0]        read_map_select;
		logic [7:0]        graphics_mode;
		logic [7:0]        bit_mask;
		int                mismatches;

		function new();
			latches          = '0;
			map_mask         = 4'hF;
			set_reset        = '0;
			enable_set_reset = '0;
			data_rotate      = '0;
			read_map_select  = '0;
			graphics_mode    = '0;
			bit_mask         = '0;
			mismatches       = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
			case (idx)
				REG_MAP_MASK:         map_mask = v[3:0];
				REG_SET_RESET:        set_reset = v[3:0];
				REG_ENABLE_SET_RESET: enable_set_reset = v[3:0];
				REG_DATA_ROTATE:      data_rotate = v[4:0];
				REG_READ_MAP_SELECT:  read_map_select = v[1:0];
				REG_GRAPHICS_MODE:    graphics_mode = v;
				REG_BIT_MASK:         bit_mask = v;
				default: ;
			endcase
		endfunction

		function void note_access(logic op, logic [ADDR_IN_W-1:0] addr, logic [DATA_W-1:0] data);
			int                a;
			wmode_t            wm;
			logic [WORD_W-1:0] word;
			logic [DATA_W-1:0] rot, lat, src, res, nb;
			bit [PLANES-1:0]   seen;
			a  = int'(addr) % PLANE_DEPTH;
			wm = wmode_t'(graphics_mode[1:0]);
			if (op == OP_READ) begin
				latches = plane_words.exists(a) ? plane_words[a] : '0;
				if (graphics_mode[GM_READ_MODE_BIT])
					read_bytes_due.push_back(READ_MODE1_DATA);
				else
					read_bytes_due.push_back(latches[8*read_map_select +: 8]);
				return;
			end
			if (wm == WM_NONE)
				return;
			word = plane_words.exists(a) ? plane_words[a] : '0;
			seen = planes_written.exists(a) ? planes_written[a] : '0;
			rot  = 8'({data, data} >> data_rotate[2:0]);
			for (int p = 0; p < PLANES; p++) begin
				if (!map_mask[p])
					continue;
				lat = latches[8*p +: 8];
				if (wm == WM_LATCH) begin
					nb = lat;
				end else begin
					if (wm == WM_ROTATE)
						src = enable_set_reset[p] ? {8{set_reset[p]}} : rot;
					else
						src = {8{data[p]}};
					case (alu_t'(data_rotate[4:3]))
						ALU_AND: res = src & lat;
						ALU_OR:  res = src | lat;
						ALU_XOR: res = src ^ lat;
						default: res = src;
					endcase
					nb = (res & bit_mask) | (lat & ~bit_mask);
				end
				word[8*p +: 8] = nb;
			end
			plane_words[a] = word;
			// Reads stay on addresses whose four plane bytes are all defined.
			if (seen != 4'hF && (seen | map_mask) == 4'hF)
				readable_addrs.push_back(a);
			planes_written[a] = seen | map_mask;
		endfunction

		function void check_read(logic [DATA_W-1:0] got);
			logic [DATA_W-1:0] want;
			if (read_bytes_due.size() == 0) begin
				$error("read_data: no read outstanding, actual %02h", got);
				mismatches++;
			end else begin
				want = read_bytes_due.pop_front();
				if (got !== want) begin
					$error("read_data: expected %02h, actual %02h", want, got);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 busy;
	logic                 operation  = OP_READ;
	logic [ADDR_IN_W-1:0] address    = '0;
	logic [DATA_W-1:0]    write_data = '0;
	logic                 done;
	logic [DATA_W-1:0]    read_data;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata  = '0;

	vram_mirror mirror = new();
	bit         gaps_on = 1'b1;
	int         accesses_sent = 0;

	ega_graphics_controller #(
		.PLANE_BYTES(PLANE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.address   (address),
		.write_data(write_data),
		.done      (done),
		.read_data (read_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every word that done marks is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_read(read_data);
	end

	// Drop start for a random number of cycles, then hold the access until
	// the block takes it. Called just after a rising edge.
	task automatic send_access(input logic op, input logic [ADDR_IN_W-1:0] a,
			input logic [DATA_W-1:0] d);
		int gap;
		gap = gaps_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		address    <= a;
		write_data <= d;
		do
			@(posedge clk);
		while (busy);
		mirror.note_access(op, a, d);
		accesses_sent++;
	endtask

	// Write one register; the enable drops for a cycle so that back-to-back
	// writes never raise and lower it in the same step.
	task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.write_register(idx, v);
		@(posedge clk);
	endtask

	// Idle the command side until every read byte is back and the last write
	// has reached memory.
	task automatic drain();
		start <= 1'b0;
		while (mirror.read_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// New settings for every register, leaning on all-zero and all-one values.
	task automatic draw_register_settings();
		logic [7:0] v;
		for (int i = 0; i <= int'(REG_BIT_MASK); i++) begin
			case ($urandom_range(0, 3))
				0:       v = 8'h00;
				1:       v = 8'hFF;
				default: v = 8'($urandom_range(0, 255));
			endcase
			// Keep the write mode spread evenly; an all-ones value would park it
			// in the mode that writes nothing.
			if (i == int'(REG_GRAPHICS_MODE))
				v = 8'($urandom_range(0, 255));
			// All planes on often enough that fresh addresses become readable.
			if (i == int'(REG_MAP_MASK) && $urandom_range(0, 2) == 0)
				v = 8'hFF;
			program_register(CFG_IDX_W'(i), v);
		end
		if ($urandom_range(0, 7) == 0)
			program_register(REG_UNUSED, 8'($urandom_range(0, 255)));
	endtask

	// Stall watchdog: too long without an accepted word ends the run.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (start && !busy)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("ega_graphics_controller regression: fail");
		$finish;
	end

	initial begin
		int                   r;
		logic [ADDR_IN_W-1:0] a;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mode 0 copy with the full bit mask: plain stores, both address ends.
		program_register(REG_BIT_MASK, 8'hFF);
		send_access(OP_WRITE, 14'd0, 8'hA5);
		send_access(OP_WRITE, 14'h3FFF, 8'h5A);
		send_access(OP_WRITE, 14'd1, 8'hFF);
		send_access(OP_WRITE, 14'd2, 8'h00);
		send_access(OP_READ, 14'd0, 8'hFF);
		send_access(OP_READ, 14'h3FFF, 8'h00);
		drain();
		program_register(REG_READ_MAP_SELECT, 8'h03);
		send_access(OP_READ, 14'd1, 8'h00);
		// Read mode 1 returns all ones.
		drain();
		program_register(REG_GRAPHICS_MODE, 8'h08);
		send_access(OP_READ, 14'd2, 8'h55);
		// Set/reset on the upper planes, rotated data on the lower ones.
		drain();
		program_register(REG_GRAPHICS_MODE, {6'd0, WM_ROTATE});
		program_register(REG_SET_RESET, 8'h05);
		program_register(REG_ENABLE_SET_RESET, 8'h0C);
		send_access(OP_WRITE, 14'd3, 8'h3C);
		send_access(OP_READ, 14'd3, 8'h00);
		// Rotate by three and AND with the latches.
		drain();
		program_register(REG_DATA_ROTATE, {3'd0, ALU_AND, 3'd3});
		send_access(OP_READ, 14'd1, 8'h00);
		send_access(OP_WRITE, 14'd4, 8'h96);
		send_access(OP_READ, 14'd4, 8'h00);
		// Latch copy: mode 1 writes the latches back.
		drain();
		program_register(REG_GRAPHICS_MODE, {6'd0, WM_LATCH});
		send_access(OP_READ, 14'd0, 8'h00);
		send_access(OP_WRITE, 14'd5, 8'hFF);
		send_access(OP_READ, 14'd5, 8'h00);
		// Expanded color bits, OR with the latches under a partial bit mask.
		drain();
		program_register(REG_GRAPHICS_MODE, {6'd0, WM_EXPAND});
		program_register(REG_DATA_ROTATE, {3'd0, ALU_OR, 3'd0});
		program_register(REG_BIT_MASK, 8'h0F);
		send_access(OP_WRITE, 14'd6, 8'h0A);
		send_access(OP_READ, 14'd6, 8'h00);
		// Mode 3 must leave memory alone.
		drain();
		program_register(REG_GRAPHICS_MODE, {6'd0, WM_NONE});
		send_access(OP_WRITE, 14'd0, 8'h77);
		drain();
		program_register(REG_GRAPHICS_MODE, {6'd0, WM_ROTATE});
		program_register(REG_DATA_ROTATE, {3'd0, ALU_XOR, 3'd7});
		program_register(REG_BIT_MASK, 8'hFF);
		send_access(OP_READ, 14'd0, 8'h00);
		// Partial map mask: planes 0 and 2 only.
		drain();
		program_register(REG_MAP_MASK, 8'h05);
		send_access(OP_WRITE, 14'd0, 8'hC3);
		send_access(OP_READ, 14'd0, 8'h00);
		drain();
		program_register(REG_UNUSED, 8'hFF);

		// Fill a pool of addresses at both ends so random reads have targets.
		program_register(REG_MAP_MASK, 8'h0F);
		program_register(REG_GRAPHICS_MODE, 8'h00);
		program_register(REG_DATA_ROTATE, 8'h00);
		for (int i = 0; i < 32; i++) begin
			a = (i < 16) ? ADDR_IN_W'(i) : ADDR_IN_W'(PLANE_DEPTH - 32 + i);
			send_access(OP_WRITE, a, 8'($urandom_range(0, 255)));
		end

		// Random phases: new settings, then a mix of reads and writes mostly
		// on the pool, now and then anywhere in the plane.
		while (accesses_sent < ACCESS_GOAL) begin
			drain();
			gaps_on = ($urandom_range(0, 3) != 0);
			draw_register_settings();
			repeat (PHASE_LEN) begin
				if (mirror.readable_addrs.size() > 0 && $urandom_range(0, 99) < 45) begin
					r = $urandom_range(0, mirror.readable_addrs.size() - 1);
					send_access(OP_READ, ADDR_IN_W'(mirror.readable_addrs[r]),
						8'($urandom_range(0, 255)));
				end else begin
					r = $urandom_range(0, 31);
					if ($urandom_range(0, 9) == 0)
						a = ADDR_IN_W'($urandom_range(0, PLANE_DEPTH - 1));
					else
						a = (r < 16) ? ADDR_IN_W'(r) : ADDR_IN_W'(PLANE_DEPTH - 32 + r);
					send_access(OP_WRITE, a, 8'($urandom_range(0, 255)));
				end
			end
		end

		drain();
		if (mirror.mismatches == 0 && mirror.read_bytes_due.size() == 0)
			$display("ega_graphics_controller regression: pass");
		else
			$display("ega_graphics_controller regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
design/egc_pkg.sv
design/egc_cfg_regs.sv
design/egc_write_unit.sv
design/egc_plane_mem.sv
design/ega_graphics_controller.sv
design/egc_checker.sv
dv/ega_graphics_controller_test.sv
